[hdl/ppcc_pkg.sv]
// ----------------------------------------------------------------------------
// ppcc_pkg
// shared types, constants and the controller/datapath interface structs of
// the pairwise proximity collision check
// ----------------------------------------------------------------------------
`default_nettype none

package ppcc_pkg;

	// sizes
	localparam int MAX_OBJECTS  = 8;
	localparam int OBJ_BITS     = $clog2(MAX_OBJECTS);
	localparam int COUNT_BITS   = 4;
	localparam int COORD_BITS   = 16;
	localparam int LIMIT_BITS   = 16;
	localparam int STEP_BITS    = 16;
	localparam int LOG_CAPACITY = 32;
	localparam int LOG_BITS     = $clog2(LOG_CAPACITY + 1);
	localparam int TOTAL_BITS   = 6;
	localparam int KIND_BITS    = 2;
	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_DATA_BITS = 16;

	typedef logic [OBJ_BITS-1:0]          obj_idx_t;
	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [KIND_BITS-1:0]         res_kind_t;

	// input word kinds
	localparam logic KIND_LOAD     = 1'b0;
	localparam logic KIND_EVALUATE = 1'b1;

	// result word kinds
	localparam res_kind_t RES_COLLISION = 2'd0;
	localparam res_kind_t RES_DEACT     = 2'd1;
	localparam res_kind_t RES_DONE      = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_OBJECT_COUNT    = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PROXIMITY_LIMIT = 1'b1;

	localparam obj_idx_t OBJ_LAST = obj_idx_t'(MAX_OBJECTS - 1);

	// controller to datapath
	typedef struct packed {
		logic     load_wr;     // write loaded position
		logic     eval_start;  // capture step, clear marks
		logic     pair_rd;     // read positions of pair a/b
		logic     emit_hit;    // emit collision record for pair a/b
		logic     emit_deact;  // emit deactivation of object a
		logic     emit_done;   // emit step finished word
		obj_idx_t idx_a;
		obj_idx_t idx_b;
	} ppcc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pair_hit;   // pair takes part and is within the limit
		logic deact_hit;  // object a is marked and active
		logic out_free;   // output register can take a word this cycle
	} ppcc_stat_t;

endpackage

`default_nettype wire

[hdl/pairwise_proximity_collision_check.sv]
// ----------------------------------------------------------------------------
// pairwise_proximity_collision_check
// all-pairs per-axis proximity check over up to eight stored 3-d positions
// ----------------------------------------------------------------------------
// A load word (kind 0) stores one object's position; while the block is idle,
// loads stream back to back. An evaluate word (kind 1) walks every pair i<j of
// the eight object slots, each with a registered read of both positions from
// the position memory and then the three absolute-difference compares, then
// sweeps the eight objects one per cycle for deactivation, save where the
// output side stalls a result, and closes with a step finished word.
// Pairs outside object_count or with an inactive object are walked but give
// nothing. A pair collides when every axis differs by at most
// proximity_limit; each collision gives a record word, and every marked object
// that is still active gives one deactivation word. The word with last set
// ends the step. Configuration writes (index 0 object_count, index 1
// proximity_limit) take effect at once and are meant for idle periods only.
// Results sit in an output register, so a new load can be taken while the
// last result still waits on out_ready. Evaluating a slot that was never
// loaded returns unspecified coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module pairwise_proximity_collision_check (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// configuration write port
	input  wire logic                                   cfg_we,
	input  wire logic [ppcc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  wire logic [ppcc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	// input words
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic                                   kind,
	input  wire logic [ppcc_pkg::OBJ_BITS-1:0]          object_index,
	input  wire logic signed [ppcc_pkg::COORD_BITS-1:0] pos_x,
	input  wire logic signed [ppcc_pkg::COORD_BITS-1:0] pos_y,
	input  wire logic signed [ppcc_pkg::COORD_BITS-1:0] pos_z,
	input  wire logic [ppcc_pkg::STEP_BITS-1:0]         step_number,
	// result words
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic [ppcc_pkg::KIND_BITS-1:0]              result_kind,
	output logic [ppcc_pkg::OBJ_BITS-1:0]               first_object,
	output logic [ppcc_pkg::OBJ_BITS-1:0]               second_object,
	output logic signed [ppcc_pkg::COORD_BITS-1:0]      hit_x,
	output logic signed [ppcc_pkg::COORD_BITS-1:0]      hit_y,
	output logic signed [ppcc_pkg::COORD_BITS-1:0]      hit_z,
	output logic [ppcc_pkg::STEP_BITS-1:0]              hit_step,
	output logic                                        logged,
	output logic                                        failed,
	output logic [ppcc_pkg::TOTAL_BITS-1:0]             collision_total,
	output logic                                        last
);
	import ppcc_pkg::*;

	ppcc_cmd_t  cmd;
	ppcc_stat_t stat;

	// sequencer: owns the pair and sweep indexes
	ppcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.stat     (stat),
		.cmd      (cmd)
	);

	// storage, compares and the result register
	ppcc_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.object_index    (object_index),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.pos_z           (pos_z),
		.step_number     (step_number),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.result_kind     (result_kind),
		.first_object    (first_object),
		.second_object   (second_object),
		.hit_x           (hit_x),
		.hit_y           (hit_y),
		.hit_z           (hit_z),
		.hit_step        (hit_step),
		.logged          (logged),
		.failed          (failed),
		.collision_total (collision_total),
		.last            (last)
	);

endmodule

`default_nettype wire

[hdl/ppcc_ctrl.sv]
// ----------------------------------------------------------------------------
// ppcc_ctrl
// sequencer: input acceptance, pair walk, deactivation sweep, step close
// ----------------------------------------------------------------------------
`default_nettype none

module ppcc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                kind,
	input  wire ppcc_pkg::ppcc_stat_t stat,
	output ppcc_pkg::ppcc_cmd_t      cmd
);
	import ppcc_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_CMP   = 3'd2;
	localparam logic [2:0] ST_DEACT = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q, state_d;
	obj_idx_t   idx_a_q, idx_a_d;
	obj_idx_t   idx_b_q, idx_b_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd       = '0;
		cmd.idx_a = idx_a_q;
		cmd.idx_b = idx_b_q;
		state_d   = state_q;
		idx_a_d   = idx_a_q;
		idx_b_d   = idx_b_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (kind == KIND_LOAD) begin
						cmd.load_wr = 1'b1;
					end else begin
						cmd.eval_start = 1'b1;
						idx_a_d        = obj_idx_t'(0);
						idx_b_d        = obj_idx_t'(1);
						state_d        = ST_READ;
					end
				end
			end
			ST_READ: begin
				cmd.pair_rd = 1'b1;
				state_d     = ST_CMP;
			end
			ST_CMP: begin
				if (!stat.pair_hit || stat.out_free) begin
					cmd.emit_hit = stat.pair_hit;
					if (idx_b_q == OBJ_LAST) begin
						if (idx_a_q == OBJ_LAST - obj_idx_t'(1)) begin
							idx_a_d = obj_idx_t'(0);
							state_d = ST_DEACT;
						end else begin
							idx_a_d = idx_a_q + obj_idx_t'(1);
							idx_b_d = idx_a_q + obj_idx_t'(2);
							state_d = ST_READ;
						end
					end else begin
						idx_b_d = idx_b_q + obj_idx_t'(1);
						state_d = ST_READ;
					end
				end
			end
			ST_DEACT: begin
				if (!stat.deact_hit || stat.out_free) begin
					cmd.emit_deact = stat.deact_hit;
					if (idx_a_q == OBJ_LAST) begin
						state_d = ST_DONE;
					end else begin
						idx_a_d = idx_a_q + obj_idx_t'(1);
					end
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.emit_done = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_a_q <= '0;
			idx_b_q <= '0;
		end else begin
			state_q <= state_d;
			idx_a_q <= idx_a_d;
			idx_b_q <= idx_b_d;
		end
	end

endmodule

`default_nettype wire

[hdl/ppcc_dp.sv]
// ----------------------------------------------------------------------------
// ppcc_dp
// datapath: position memory, config, flags, pair compare, output register
// ----------------------------------------------------------------------------
`default_nettype none

module ppcc_dp (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire ppcc_pkg::ppcc_cmd_t                   cmd,
	output ppcc_pkg::ppcc_stat_t                       stat,
	input  wire logic                                  cfg_we,
	input  wire logic [ppcc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  wire logic [ppcc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  wire logic [ppcc_pkg::OBJ_BITS-1:0]         object_index,
	input  wire logic signed [ppcc_pkg::COORD_BITS-1:0] pos_x,
	input  wire logic signed [ppcc_pkg::COORD_BITS-1:0] pos_y,
	input  wire logic signed [ppcc_pkg::COORD_BITS-1:0] pos_z,
	input  wire logic [ppcc_pkg::STEP_BITS-1:0]        step_number,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [ppcc_pkg::KIND_BITS-1:0]             result_kind,
	output logic [ppcc_pkg::OBJ_BITS-1:0]              first_object,
	output logic [ppcc_pkg::OBJ_BITS-1:0]              second_object,
	output logic signed [ppcc_pkg::COORD_BITS-1:0]     hit_x,
	output logic signed [ppcc_pkg::COORD_BITS-1:0]     hit_y,
	output logic signed [ppcc_pkg::COORD_BITS-1:0]     hit_z,
	output logic [ppcc_pkg::STEP_BITS-1:0]             hit_step,
	output logic                                       logged,
	output logic                                       failed,
	output logic [ppcc_pkg::TOTAL_BITS-1:0]            collision_total,
	output logic                                       last
);
	import ppcc_pkg::*;

	localparam int POS_BITS = 3 * COORD_BITS;

	// magnitude of a - b, one bit wider than a coordinate
	function automatic logic [COORD_BITS:0] abs_diff(input coord_t a, input coord_t b);
		logic signed [COORD_BITS:0] d;
		d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
		abs_diff = d[COORD_BITS] ? (COORD_BITS+1)'(-d) : (COORD_BITS+1)'(d);
	endfunction

	// config registers
	logic [COUNT_BITS-1:0] obj_count_q;
	logic [LIMIT_BITS-1:0] limit_q;

	// state
	logic [MAX_OBJECTS-1:0] active_q;
	logic [MAX_OBJECTS-1:0] mark_q;
	logic [LOG_BITS-1:0]    log_cnt_q;
	logic                   fail_q;
	logic [STEP_BITS-1:0]   step_q;

	// position memory, x/y/z packed per object, registered two-port read
	logic [POS_BITS-1:0] pos_mem [MAX_OBJECTS];
	logic [POS_BITS-1:0] rd_a_q, rd_b_q;

	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			pos_mem[object_index] <= {pos_x, pos_y, pos_z};
		end
		if (cmd.pair_rd) begin
			rd_a_q <= pos_mem[cmd.idx_a];
			rd_b_q <= pos_mem[cmd.idx_b];
		end
	end

	coord_t ax, ay, az, bx, by, bz;
	assign {ax, ay, az} = rd_a_q;
	assign {bx, by, bz} = rd_b_q;

	logic [COORD_BITS:0] lim_ext;
	logic                near, takes_part;
	logic                log_room;
	logic [LOG_BITS-1:0] log_cnt_next;
	logic                out_valid_q;

	assign lim_ext = (COORD_BITS+1)'(limit_q);
	assign near    = (abs_diff(ax, bx) <= lim_ext) && (abs_diff(ay, by) <= lim_ext)
		&& (abs_diff(az, bz) <= lim_ext);
	// counts above the object limit compare as "all objects"
	assign takes_part = ({1'b0, cmd.idx_a} < obj_count_q) && ({1'b0, cmd.idx_b} < obj_count_q)
		&& active_q[cmd.idx_a] && active_q[cmd.idx_b];

	assign log_room     = (log_cnt_q < LOG_BITS'(LOG_CAPACITY));
	assign log_cnt_next = log_room ? log_cnt_q + LOG_BITS'(1) : log_cnt_q;

	assign stat.pair_hit  = takes_part && near;
	assign stat.deact_hit = mark_q[cmd.idx_a] && active_q[cmd.idx_a];
	assign stat.out_free  = !out_valid_q || out_ready;

	// config write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_count_q <= COUNT_BITS'(MAX_OBJECTS);
			limit_q     <= LIMIT_BITS'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OBJECT_COUNT:    obj_count_q <= cfg_data[COUNT_BITS-1:0];
				REG_PROXIMITY_LIMIT: limit_q     <= cfg_data[LIMIT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// flags, marks, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '1;
			mark_q    <= '0;
			log_cnt_q <= '0;
			fail_q    <= 1'b0;
		end else begin
			if (cmd.eval_start) begin
				mark_q <= '0;
			end
			if (cmd.emit_hit) begin
				mark_q[cmd.idx_a] <= 1'b1;
				mark_q[cmd.idx_b] <= 1'b1;
				log_cnt_q         <= log_cnt_next;
				fail_q            <= 1'b1;
			end
			if (cmd.emit_deact) begin
				active_q[cmd.idx_a] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval_start) begin
			step_q <= step_number;
		end
	end

	// output register
	logic                  emit_any;
	logic [KIND_BITS-1:0]  kind_q;
	obj_idx_t              first_q, second_q;
	coord_t                hx_q, hy_q, hz_q;
	logic [STEP_BITS-1:0]  hstep_q;
	logic                  logged_q, failed_q, last_q;
	logic [LOG_BITS-1:0]   total_q;

	assign emit_any = cmd.emit_hit || cmd.emit_deact || cmd.emit_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_any) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// step is held with the word so a new evaluate cannot change a waiting word
	always_ff @(posedge clk) begin
		if (emit_any) begin
			first_q  <= '0;
			second_q <= '0;
			hx_q     <= '0;
			hy_q     <= '0;
			hz_q     <= '0;
			hstep_q  <= step_q;
			logged_q <= 1'b0;
			last_q   <= 1'b0;
			failed_q <= fail_q;
			total_q  <= log_cnt_q;
			priority if (cmd.emit_hit) begin
				kind_q   <= RES_COLLISION;
				first_q  <= cmd.idx_a;
				second_q <= cmd.idx_b;
				hx_q     <= ax;
				hy_q     <= ay;
				hz_q     <= az;
				logged_q <= log_room;
				failed_q <= 1'b1;
				total_q  <= log_cnt_next;
			end else if (cmd.emit_deact) begin
				kind_q  <= RES_DEACT;
				first_q <= cmd.idx_a;
			end else begin
				kind_q <= RES_DONE;
				last_q <= 1'b1;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign result_kind     = kind_q;
	assign first_object    = first_q;
	assign second_object   = second_q;
	assign hit_x           = hx_q;
	assign hit_y           = hy_q;
	assign hit_z           = hz_q;
	assign hit_step        = hstep_q;
	assign logged          = logged_q;
	assign failed          = failed_q;
	assign collision_total = TOTAL_BITS'(total_q);
	assign last            = last_q;

endmodule

`default_nettype wire

[verif/proximity_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// proximity_result_checker
// watches the config port and both word channels of the collision check,
// predicts every result word and compares it field by field
// ----------------------------------------------------------------------------

module proximity_result_checker
	import ppcc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic                     kind,
	input  logic [OBJ_BITS-1:0]      object_index,
	input  coord_t                   pos_x,
	input  coord_t                   pos_y,
	input  coord_t                   pos_z,
	input  logic [STEP_BITS-1:0]     step_number,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic [KIND_BITS-1:0]     result_kind,
	input  logic [OBJ_BITS-1:0]      first_object,
	input  logic [OBJ_BITS-1:0]      second_object,
	input  coord_t                   hit_x,
	input  coord_t                   hit_y,
	input  coord_t                   hit_z,
	input  logic [STEP_BITS-1:0]     hit_step,
	input  logic                     logged,
	input  logic                     failed,
	input  logic [TOTAL_BITS-1:0]    collision_total,
	input  logic                     last,
	output int                       mismatch_count,
	output int                       words_outstanding
);

	typedef struct {
		res_kind_t              kind;
		obj_idx_t               first_obj;
		obj_idx_t               second_obj;
		coord_t                 hx;
		coord_t                 hy;
		coord_t                 hz;
		logic [STEP_BITS-1:0]   step;
		logic                   logged_bit;
		logic                   failed_bit;
		logic [TOTAL_BITS-1:0]  total;
		logic                   last_bit;
	} result_word_t;

	coord_t                  store_x [MAX_OBJECTS];
	coord_t                  store_y [MAX_OBJECTS];
	coord_t                  store_z [MAX_OBJECTS];
	logic [MAX_OBJECTS-1:0]  alive;
	logic [MAX_OBJECTS-1:0]  marked;
	int                      log_count;
	logic                    fail_seen;
	logic [COUNT_BITS-1:0]   cfg_count;
	logic [LIMIT_BITS-1:0]   cfg_limit;
	result_word_t            expected_words [$];

	function automatic int axis_gap(coord_t a, coord_t b);
		int d;
		d = int'(a) - int'(b);
		return (d < 0) ? -d : d;
	endfunction

	task automatic push_word(input res_kind_t k, input int f, input int s, input coord_t x,
			input coord_t y, input coord_t z, input logic [STEP_BITS-1:0] step,
			input logic lg, input logic lst);
		result_word_t w;
		w.kind       = k;
		w.first_obj  = obj_idx_t'(f);
		w.second_obj = obj_idx_t'(s);
		w.hx         = x;
		w.hy         = y;
		w.hz         = z;
		w.step       = step;
		w.logged_bit = lg;
		w.failed_bit = fail_seen;
		w.total      = TOTAL_BITS'(log_count);
		w.last_bit   = lst;
		expected_words.push_back(w);
	endtask

	// one evaluate word: pair walk, deactivation sweep, closing word
	task automatic walk_pairs(input logic [STEP_BITS-1:0] step);
		int  n;
		int  lim;
		logic lg;
		n   = (cfg_count > MAX_OBJECTS) ? MAX_OBJECTS : int'(cfg_count);
		lim = int'(cfg_limit);
		marked = '0;
		for (int i = 0; i < n; i++) begin
			if (!alive[i])
				continue;
			for (int j = i + 1; j < n; j++) begin
				if (!alive[j])
					continue;
				if (axis_gap(store_x[i], store_x[j]) > lim ||
						axis_gap(store_y[i], store_y[j]) > lim ||
						axis_gap(store_z[i], store_z[j]) > lim)
					continue;
				lg = 1'b0;
				if (log_count < LOG_CAPACITY) begin
					log_count++;
					lg = 1'b1;
				end
				fail_seen = 1'b1;
				marked[i] = 1'b1;
				marked[j] = 1'b1;
				push_word(RES_COLLISION, i, j, store_x[i], store_y[i], store_z[i], step, lg, 1'b0);
			end
		end
		for (int i = 0; i < n; i++) begin
			if (marked[i] && alive[i]) begin
				alive[i] = 1'b0;
				push_word(RES_DEACT, i, 0, '0, '0, '0, step, 1'b0, 1'b0);
			end
		end
		push_word(RES_DONE, 0, 0, '0, '0, '0, step, 1'b0, 1'b1);
	endtask

	task automatic check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_word_t w;
		if (!arst_n) begin
			for (int i = 0; i < MAX_OBJECTS; i++) begin
				store_x[i] = '0;
				store_y[i] = '0;
				store_z[i] = '0;
			end
			alive             = '1;
			marked            = '0;
			log_count         = 0;
			fail_seen         = 1'b0;
			cfg_count         = COUNT_BITS'(MAX_OBJECTS);
			cfg_limit         = LIMIT_BITS'(1);
			mismatch_count    = 0;
			expected_words.delete();
			words_outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_OBJECT_COUNT: cfg_count = cfg_data[COUNT_BITS-1:0];
					REG_PROXIMITY_LIMIT: cfg_limit = cfg_data[LIMIT_BITS-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (kind == KIND_LOAD) begin
					store_x[object_index] = pos_x;
					store_y[object_index] = pos_y;
					store_z[object_index] = pos_z;
				end else begin
					walk_pairs(step_number);
				end
			end
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$error("result word with nothing expected: kind %0d step %0d",
						result_kind, hit_step);
					mismatch_count++;
				end else begin
					w = expected_words.pop_front();
					check_field("result_kind", w.kind, result_kind);
					check_field("first_object", w.first_obj, first_object);
					check_field("second_object", w.second_obj, second_object);
					check_field("hit_x", w.hx, hit_x);
					check_field("hit_y", w.hy, hit_y);
					check_field("hit_z", w.hz, hit_z);
					check_field("hit_step", w.step, hit_step);
					check_field("logged", w.logged_bit, logged);
					check_field("failed", w.failed_bit, failed);
					check_field("collision_total", w.total, collision_total);
					check_field("last", w.last_bit, last);
				end
			end
			words_outstanding = expected_words.size();
		end
	end

endmodule

[verif/pairwise_proximity_collision_check_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pairwise_proximity_collision_check_test
// directed and random load/evaluate traffic with random stalls on both sides
// ----------------------------------------------------------------------------
// All eight position slots are loaded before the first evaluate so no pair
// ever reads an unwritten slot. Objects 0 and 1 sit at opposite corners of the
// coordinate range and are never reloaded; they only collide in the closing
// phase, where the proximity limit is at its maximum. Objects deactivate for
// good once they collide, so the random phases keep the limit small and only
// sometimes drop a load near another object.
// ----------------------------------------------------------------------------

module pairwise_proximity_collision_check_test;

	import ppcc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no accepted word
	localparam int SETTLE_CYCLES  = 80;    // above one full pair walk
	localparam int RANDOM_ITEMS   = 340;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	logic                     kind;
	logic [OBJ_BITS-1:0]      object_index;
	coord_t                   pos_x;
	coord_t                   pos_y;
	coord_t                   pos_z;
	logic [STEP_BITS-1:0]     step_number;
	logic                     out_valid;
	logic                     out_ready;
	logic [KIND_BITS-1:0]     result_kind;
	logic [OBJ_BITS-1:0]      first_object;
	logic [OBJ_BITS-1:0]      second_object;
	coord_t                   hit_x;
	coord_t                   hit_y;
	coord_t                   hit_z;
	logic [STEP_BITS-1:0]     hit_step;
	logic                     logged;
	logic                     failed;
	logic [TOTAL_BITS-1:0]    collision_total;
	logic                     last;

	int mismatch_count;
	int words_outstanding;

	// stimulus-side copy of the loaded positions, only used to aim near loads
	coord_t shadow_x [MAX_OBJECTS];
	coord_t shadow_y [MAX_OBJECTS];
	coord_t shadow_z [MAX_OBJECTS];
	int     cur_limit = 1;

	int quiet_cycles = 0;
	int burst_left   = 0;
	int ready_hold   = 0;
	int calm_left    = 0;
	int ready_roll;

	pairwise_proximity_collision_check uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.object_index    (object_index),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.pos_z           (pos_z),
		.step_number     (step_number),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.result_kind     (result_kind),
		.first_object    (first_object),
		.second_object   (second_object),
		.hit_x           (hit_x),
		.hit_y           (hit_y),
		.hit_z           (hit_z),
		.hit_step        (hit_step),
		.logged          (logged),
		.failed          (failed),
		.collision_total (collision_total),
		.last            (last)
	);

	proximity_result_checker result_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.kind              (kind),
		.object_index      (object_index),
		.pos_x             (pos_x),
		.pos_y             (pos_y),
		.pos_z             (pos_z),
		.step_number       (step_number),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.result_kind       (result_kind),
		.first_object      (first_object),
		.second_object     (second_object),
		.hit_x             (hit_x),
		.hit_y             (hit_y),
		.hit_z             (hit_z),
		.hit_step          (hit_step),
		.logged            (logged),
		.failed            (failed),
		.collision_total   (collision_total),
		.last              (last),
		.mismatch_count    (mismatch_count),
		.words_outstanding (words_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: any accepted word or register write restarts the count
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("** pairwise_proximity_collision_check: FAILED **");
		$finish;
	end

	// result side back-pressure: calm stretches, short stalls, a few long ones
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (calm_left > 0) begin
				calm_left--;
				out_ready <= 1'b1;
			end else if (ready_hold > 0) begin
				ready_hold--;
			end else begin
				ready_roll = $urandom_range(0, 99);
				if (ready_roll < 5) begin
					calm_left = $urandom_range(30, 150);
					out_ready <= 1'b1;
				end else if (out_ready) begin
					out_ready <= 1'b0;
					ready_hold = (ready_roll < 15) ? $urandom_range(10, 40) : $urandom_range(0, 2);
				end else begin
					out_ready <= 1'b1;
					ready_hold = $urandom_range(0, 6);
				end
			end
		end
	end

	// gap before the next input word; zero during back-to-back bursts
	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 8) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		if (r < 40)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	// present one input word and hold it until the block takes it
	task automatic send_word(input logic k, input obj_idx_t idx, input coord_t x,
			input coord_t y, input coord_t z, input logic [STEP_BITS-1:0] step);
		int gap;
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		kind         <= k;
		object_index <= idx;
		pos_x        <= x;
		pos_y        <= y;
		pos_z        <= z;
		step_number  <= step;
		if (k == KIND_LOAD) begin
			shadow_x[idx] = x;
			shadow_y[idx] = y;
			shadow_z[idx] = z;
		end
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic send_evaluate(input logic [STEP_BITS-1:0] step);
		send_word(KIND_EVALUATE, obj_idx_t'($urandom), coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom), step);
	endtask

	// registers only change with nothing in flight: drain, let the walk finish
	task automatic set_config(input logic [CFG_DATA_BITS-1:0] count,
			input logic [CFG_DATA_BITS-1:0] limit);
		@(negedge clk);
		in_valid <= 1'b0;
		while (words_outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_OBJECT_COUNT;
		cfg_data  <= count;
		@(negedge clk);
		cfg_index <= REG_PROXIMITY_LIMIT;
		cfg_data  <= limit;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_limit = int'(limit);
	endtask

	// coordinate within the current limit of c, kept inside the signed range
	function automatic coord_t nudge(coord_t c);
		int v;
		v = int'(c) + int'($urandom_range(0, 2 * cur_limit)) - cur_limit;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return coord_t'(v);
	endfunction

	// random load into slots 2..7; one in six lands near another object
	task automatic random_load();
		obj_idx_t idx;
		obj_idx_t src;
		coord_t   x;
		coord_t   y;
		coord_t   z;
		idx = obj_idx_t'($urandom_range(2, MAX_OBJECTS - 1));
		if ($urandom_range(0, 5) == 0) begin
			src = obj_idx_t'($urandom_range(2, MAX_OBJECTS - 1));
			x = nudge(shadow_x[src]);
			y = nudge(shadow_y[src]);
			z = nudge(shadow_z[src]);
		end else begin
			x = coord_t'($urandom);
			y = coord_t'($urandom);
			z = coord_t'($urandom);
		end
		send_word(KIND_LOAD, idx, x, y, z, STEP_BITS'($urandom));
	endtask

	initial begin
		int items;
		int phase_len;
		logic [CFG_DATA_BITS-1:0] count;
		logic [CFG_DATA_BITS-1:0] limit;

		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		kind         = KIND_LOAD;
		object_index = '0;
		pos_x        = '0;
		pos_y        = '0;
		pos_z        = '0;
		step_number  = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// directed part, reset config: eight objects, limit 1
		// opposite corners in slots 0 and 1, one pair at distance 1 in 2 and 3,
		// one pair just out of reach in 4 and 5
		send_word(KIND_LOAD, 3'd0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'h0000);
		send_word(KIND_LOAD, 3'd1, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'hFFFF);
		send_word(KIND_LOAD, 3'd2, 16'sd0, 16'sd0, 16'sd0, 16'h5555);
		send_word(KIND_LOAD, 3'd3, 16'sd1, -16'sd1, 16'sd1, 16'hAAAA);
		send_word(KIND_LOAD, 3'd4, 16'sd1000, 16'sd1000, 16'sd1000, 16'h0001);
		send_word(KIND_LOAD, 3'd5, 16'sd1002, 16'sd1000, 16'sd999, 16'h8000);
		send_word(KIND_LOAD, 3'd6, -16'sd5000, 16'sd12345, -16'sd20000, 16'h00FF);
		send_word(KIND_LOAD, 3'd7, 16'sd20000, -16'sd20000, 16'sd3, 16'hFF00);

		// corners differ by 65535 on every axis: one above the limit
		set_config(16'd2, 16'hFFFE);
		send_evaluate(16'h0000);

		// zero objects: only the closing word
		set_config(16'd0, 16'hFFFF);
		send_evaluate(16'hFFFF);

		// count above the slot total acts as eight; slots 2 and 3 collide
		set_config(16'd15, 16'd1);
		send_evaluate(16'h8001);

		// a load on top of a deactivated object must not bring it back
		send_word(KIND_LOAD, 3'd2, 16'sd1, -16'sd1, 16'sd1, 16'h1234);
		send_evaluate(16'h7FFE);

		// random phases, each under its own config; the last one opens the
		// limit fully so every object still active collides, corners included
		items = 0;
		while (items < RANDOM_ITEMS) begin
			phase_len = $urandom_range(15, 45);
			if (items + phase_len >= RANDOM_ITEMS) begin
				phase_len = RANDOM_ITEMS - items;
				set_config(CFG_DATA_BITS'(MAX_OBJECTS), 16'hFFFF);
			end else begin
				if ($urandom_range(0, 5) == 0)
					count = CFG_DATA_BITS'($urandom_range(0, 15));
				else
					count = CFG_DATA_BITS'($urandom_range(3, MAX_OBJECTS));
				case ($urandom_range(0, 4))
					0: limit = 16'd0;
					1, 2: limit = CFG_DATA_BITS'($urandom_range(1, 16));
					default: limit = CFG_DATA_BITS'($urandom_range(17, 1023));
				endcase
				set_config(count, limit);
			end
			repeat (phase_len) begin
				if ($urandom_range(0, 3) == 0)
					send_evaluate(STEP_BITS'($urandom));
				else
					random_load();
				items++;
			end
		end
		send_evaluate(STEP_BITS'($urandom));

		// drain, then give a stray word time to show up
		@(negedge clk);
		in_valid <= 1'b0;
		while (words_outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && words_outstanding == 0)
			$display("** pairwise_proximity_collision_check: PASSED **");
		else
			$display("** pairwise_proximity_collision_check: FAILED **");
		$finish;
	end

endmodule

[sim.f]
hdl/ppcc_pkg.sv
hdl/ppcc_ctrl.sv
hdl/ppcc_dp.sv
hdl/pairwise_proximity_collision_check.sv
verif/proximity_result_checker.sv
verif/pairwise_proximity_collision_check_test.sv
